>>> src/dcd_pkg.sv
`default_nettype none
package dcd_pkg;
  localparam int unsigned MaxProcesses = 16;
  localparam int unsigned MaxResources = 16;

  localparam logic [1:0] KindNone    = 2'd0;
  localparam logic [1:0] KindHeld    = 2'd1;
  localparam logic [1:0] KindRequest = 2'd2;

  localparam logic RegNumProcesses = 1'b0;
  localparam logic RegNumResources = 1'b1;

  // Clamp a configured count into 1..max
  function automatic logic [6:0] clamp_count(logic [4:0] v, logic [6:0] max);
    logic [6:0] r;
    begin
      r = {2'b00, v};
      if (v == 5'd0) r = 7'd1;
      else if (r > max) r = max;
      return r;
    end
  endfunction
endpackage
`default_nettype wire

>>> src/dcd_walk.sv
`default_nettype none
// Sequencer that builds the wait-for rows, then runs an iterative DFS.
module dcd_walk import dcd_pkg::*; #(
  parameter int unsigned MAX_PROCESSES = MaxProcesses,
  parameter int unsigned MAX_RESOURCES = MaxResources,
  localparam int unsigned PW = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1,
  localparam int unsigned RW = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [PW:0]   np_i,
  input  wire logic [RW:0]   nr_i,
  output logic [PW-1:0]      rd_p_o,
  output logic [RW-1:0]      rd_r_o,
  input  wire logic [1:0]    rd_kind_i,
  output logic               done_o,
  output logic               dead_o
);
  typedef enum logic [5:0] {
    StIdle  = 6'b000001,
    StReq   = 6'b000010,
    StHeld  = 6'b000100,
    StStart = 6'b001000,
    StWalk  = 6'b010000,
    StDone  = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic [PW-1:0] i_q, i_d, k_q, k_d, s_q, s_d;
  logic [RW-1:0] r_q, r_d;
  logic [PW:0]   top_q, top_d;
  logic          dead_q, dead_d;
  logic [MAX_PROCESSES-1:0] wait_q [MAX_PROCESSES];
  logic [MAX_PROCESSES-1:0] row_d;
  logic          row_we;
  logic [MAX_PROCESSES-1:0] vis_q, vis_d, onp_q, onp_d;
  logic [PW-1:0] stk_q [MAX_PROCESSES];
  logic [PW:0]   nstk_q [MAX_PROCESSES];
  logic          stk_we, nxt_we;
  logic [PW-1:0] stk_wa, stk_wd, p_cur;
  logic [PW-1:0] nxt_wa, i_cur;
  logic [PW:0]   nxt_wd;

  localparam logic [PW:0] MaxTop = (PW+1)'(MAX_PROCESSES);

  assign p_cur = stk_q[top_q[PW-1:0] - PW'(1)];
  assign i_cur = nstk_q[top_q[PW-1:0] - PW'(1)][PW-1:0];

  // Sequencer: one edge-store read or one walk step per cycle
  always_comb begin
    state_d = state_q;
    i_d = i_q; k_d = k_q; r_d = r_q; s_d = s_q;
    top_d = top_q; dead_d = dead_q;
    vis_d = vis_q; onp_d = onp_q;
    row_d = wait_q[i_q]; row_we = 1'b0;
    stk_we = 1'b0; stk_wa = '0; stk_wd = '0;
    nxt_we = 1'b0; nxt_wa = '0; nxt_wd = '0;
    rd_p_o = i_q; rd_r_o = r_q;
    done_o = 1'b0;
    case (state_q)
      StIdle: begin
        if (start_i) begin
          i_d = '0; r_d = '0; k_d = '0; dead_d = 1'b0;
          state_d = StReq;
          row_we = 1'b1; row_d = '0;
        end
      end
      StReq: begin
        rd_p_o = i_q; rd_r_o = r_q;
        if (rd_kind_i == KindRequest) begin
          k_d = '0; state_d = StHeld;
        end else if ({1'b0, r_q} + (RW+1)'(1) < nr_i) begin
          r_d = r_q + RW'(1);
        end else if ({1'b0, i_q} + (PW+1)'(1) < np_i) begin
          i_d = i_q + PW'(1); r_d = '0;
        end else begin
          s_d = '0; vis_d = '0; onp_d = '0; state_d = StStart;
        end
      end
      StHeld: begin
        rd_p_o = k_q; rd_r_o = r_q;
        if (rd_kind_i == KindHeld) begin
          row_we = 1'b1; row_d = wait_q[i_q] | (MAX_PROCESSES'(1) << k_q);
        end
        if ({1'b0, k_q} + (PW+1)'(1) < np_i) begin
          k_d = k_q + PW'(1);
        end else if ({1'b0, r_q} + (RW+1)'(1) < nr_i) begin
          r_d = r_q + RW'(1); state_d = StReq;
        end else if ({1'b0, i_q} + (PW+1)'(1) < np_i) begin
          i_d = i_q + PW'(1); r_d = '0; state_d = StReq;
        end else begin
          s_d = '0; vis_d = '0; onp_d = '0; state_d = StStart;
        end
      end
      StStart: begin
        if (vis_q[s_q]) begin
          if ({1'b0, s_q} + (PW+1)'(1) < np_i) s_d = s_q + PW'(1);
          else state_d = StDone;
        end else begin
          stk_we = 1'b1; stk_wa = '0; stk_wd = s_q;
          nxt_we = 1'b1; nxt_wa = '0; nxt_wd = '0;
          top_d = (PW+1)'(1);
          vis_d[s_q] = 1'b1; onp_d[s_q] = 1'b1;
          state_d = StWalk;
        end
      end
      StWalk: begin
        if (top_q == '0) begin
          if ({1'b0, s_q} + (PW+1)'(1) < np_i) begin
            s_d = s_q + PW'(1); state_d = StStart;
          end else state_d = StDone;
        end else if (nstk_q[top_q[PW-1:0] - PW'(1)] >= np_i) begin
          onp_d[p_cur] = 1'b0;
          top_d = top_q - (PW+1)'(1);
        end else begin
          nxt_we = 1'b1; nxt_wa = top_q[PW-1:0] - PW'(1);
          nxt_wd = nstk_q[top_q[PW-1:0] - PW'(1)] + (PW+1)'(1);
          if (wait_q[p_cur][i_cur]) begin
            if (onp_q[i_cur]) begin
              dead_d = 1'b1; state_d = StDone;
            end else if (!vis_q[i_cur] && top_q < MaxTop) begin
              vis_d[i_cur] = 1'b1; onp_d[i_cur] = 1'b1;
              stk_we = 1'b1; stk_wa = top_q[PW-1:0]; stk_wd = i_cur;
              top_d = top_q + (PW+1)'(1);
            end
          end
        end
      end
      StDone: begin
        done_o = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      dead_q  <= 1'b0;
      top_q   <= '0;
      vis_q   <= '0;
      onp_q   <= '0;
    end else begin
      state_q <= state_d;
      dead_q  <= dead_d;
      top_q   <= top_d;
      vis_q   <= vis_d;
      onp_q   <= onp_d;
    end
  end

  // Hold counters, rows and walk frames; clear a row as the build enters it
  always_ff @(posedge clk_i) begin
    i_q <= i_d; k_q <= k_d; r_q <= r_d; s_q <= s_d;
    if (row_we) wait_q[i_q] <= row_d;
    if (row_we && state_q == StIdle) wait_q[i_d] <= '0;
    if (stk_we) stk_q[stk_wa] <= stk_wd;
    if (nxt_we) nstk_q[nxt_wa] <= nxt_wd;
    if (stk_we && state_q == StWalk) nstk_q[stk_wa] <= '0;
    if ((state_q == StReq || state_q == StHeld) && state_d == StReq && i_d != i_q)
      wait_q[i_d] <= '0;
  end

  assign dead_o = dead_q;
endmodule
`default_nettype wire

>>> src/deadlock_cycle_detector.sv
`default_nettype none
// Deadlock detector over a single-instance resource allocation graph.
// Slave stream: one graph entry per transfer (process, resource, edge kind),
// with tlast marking the final entry of a graph. Plain entries are taken one
// per cycle while tready is high and written into the edge store. The last
// entry starts a walk: the sequencer first reads the store to build one
// wait-for row per process, then runs a depth-first search over those rows,
// one edge test per cycle. tready stays low during the walk. The verdict
// leaves on the master stream as one transfer and is held in an output
// register until taken; meanwhile the edge store is swept clear, one row
// per cycle. New entries are accepted once the verdict is taken and the
// sweep is over. Reset clears control state and sweeps the edge store the
// same way; configuration writes over APB are taken at any time.
// Registers: 0x0 num_processes, 0x4 num_resources.
module deadlock_cycle_detector import dcd_pkg::*; #(
  parameter int unsigned MAX_PROCESSES = MaxProcesses,
  parameter int unsigned MAX_RESOURCES = MaxResources
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // process_index[3:0], resource_index[7:4],
                                          // edge_kind[9:8], zero fill
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata   // deadlock[0], zero fill
);
  localparam int unsigned PW = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
  localparam int unsigned RW = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;

  logic [4:0] np_reg_q, nr_reg_q;
  logic [6:0] np_c, nr_c;
  logic [PW:0] np;
  logic [RW:0] nr;
  logic [2*MAX_RESOURCES-1:0] store_q [MAX_PROCESSES];
  logic       busy_q, clr_q, ovalid_q, odata_q;
  logic [PW:0] clr_cnt_q;
  logic [PW-1:0] rd_p;
  logic [RW-1:0] rd_r;
  logic [1:0] rd_kind, kind;
  logic       done, dead, acc;
  logic [3:0] in_p, in_r;

  // Configuration registers
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      np_reg_q <= 5'd16; nr_reg_q <= 5'd16;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      if (paddr[2] == RegNumProcesses) np_reg_q <= pwdata[4:0];
      else nr_reg_q <= pwdata[4:0];
    end
  end
  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      if (paddr[2] == RegNumProcesses) prdata[4:0] = np_reg_q;
      else prdata[4:0] = nr_reg_q;
    end
  end

  assign np_c = clamp_count(np_reg_q, 7'(MAX_PROCESSES));
  assign nr_c = clamp_count(nr_reg_q, 7'(MAX_RESOURCES));
  assign np = np_c[PW:0];
  assign nr = nr_c[RW:0];

  assign in_p = s_axis_tdata[3:0];
  assign in_r = s_axis_tdata[7:4];
  assign kind = (s_axis_tdata[9:8] == 2'd3) ? KindNone : s_axis_tdata[9:8];
  assign s_axis_tready = !busy_q && !clr_q && !ovalid_q;
  assign acc = s_axis_tvalid && s_axis_tready;

  // Edge store: one row word per process, swept clear a row a cycle
  assign rd_kind = store_q[rd_p][{rd_r, 1'b0} +: 2];
  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      store_q[clr_cnt_q[PW-1:0]] <= '0;
    end else if (acc && 32'(in_p) < MAX_PROCESSES && 32'(in_r) < MAX_RESOURCES) begin
      store_q[PW'(in_p)][{RW'(in_r), 1'b0} +: 2] <= kind;
    end
  end

  // Control: busy during walk, clear sweep after verdict and reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; clr_q <= 1'b1; clr_cnt_q <= '0;
      ovalid_q <= 1'b0; odata_q <= 1'b0;
    end else begin
      if (acc && s_axis_tlast) busy_q <= 1'b1;
      if (done) begin
        busy_q <= 1'b0; ovalid_q <= 1'b1; odata_q <= dead;
        clr_q <= 1'b1; clr_cnt_q <= '0;
      end
      if (clr_q) begin
        if (clr_cnt_q == (PW+1)'(MAX_PROCESSES - 1)) clr_q <= 1'b0;
        clr_cnt_q <= clr_cnt_q + (PW+1)'(1);
      end
      if (ovalid_q && m_axis_tready) ovalid_q <= 1'b0;
    end
  end

  dcd_walk #(
    .MAX_PROCESSES(MAX_PROCESSES),
    .MAX_RESOURCES(MAX_RESOURCES)
  ) u_walk (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (acc && s_axis_tlast),
    .np_i      (np),
    .nr_i      (nr),
    .rd_p_o    (rd_p),
    .rd_r_o    (rd_r),
    .rd_kind_i (rd_kind),
    .done_o    (done),
    .dead_o    (dead)
  );

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {7'd0, odata_q};
endmodule
`default_nettype wire

>>> tb/deadlock_cycle_detector_checker.sv
`timescale 1ns / 1ps
module deadlock_cycle_detector_checker import dcd_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  input  wire logic        pready,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // process_index[3:0], resource_index[7:4],
                                          // edge_kind[9:8], zero fill
  input  wire logic        s_axis_tlast,
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [7:0]  m_axis_tdata,  // deadlock[0], zero fill
  output int               errors_o,
  output int               pending_o,
  output int               verdicts_o,
  output int               deadlocks_o
);

  logic [1:0] graph_edges [MaxProcesses][MaxResources];
  logic [4:0] proc_count;
  logic [4:0] res_count;
  bit         verdict_q [$];

  // Build the wait-for rows, then peel off processes that wait on nobody left;
  // whatever survives the peeling sits on a cycle.
  function automatic bit wait_graph_cyclic();
    int           np;
    int           nr;
    logic [15:0]  waits [16];
    logic [15:0]  alive;
    bit           changed;
    np = (proc_count == 0) ? 1 : ((proc_count > MaxProcesses) ? MaxProcesses : proc_count);
    nr = (res_count == 0) ? 1 : ((res_count > MaxResources) ? MaxResources : res_count);
    alive = '0;
    for (int i = 0; i < np; i++) begin
      waits[i] = '0;
      alive[i] = 1'b1;
      for (int r = 0; r < nr; r++) begin
        if (graph_edges[i][r] == KindRequest) begin
          for (int k = 0; k < np; k++)
            if (graph_edges[k][r] == KindHeld) waits[i][k] = 1'b1;
        end
      end
    end
    changed = 1'b1;
    while (changed) begin
      changed = 1'b0;
      for (int i = 0; i < np; i++) begin
        if (alive[i] && (waits[i] & alive) == '0) begin
          alive[i] = 1'b0;
          changed = 1'b1;
        end
      end
    end
    return alive != '0;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t ns: verdict mismatch: %s", $realtime, what);
    errors_o++;
  endtask

  // Track register writes, load entries, predict on last, compare verdicts
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (graph_edges[i, j]) graph_edges[i][j] = KindNone;
      proc_count = 5'd16;
      res_count = 5'd16;
      verdict_q.delete();
      errors_o = 0;
      pending_o = 0;
      verdicts_o = 0;
      deadlocks_o = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == {RegNumProcesses, 2'b00}) proc_count = pwdata[4:0];
        else if (paddr == {RegNumResources, 2'b00}) res_count = pwdata[4:0];
      end
      if (m_axis_tvalid && m_axis_tready) begin
        verdicts_o++;
        if (m_axis_tdata[0]) deadlocks_o++;
        if (verdict_q.size() == 0) begin
          report_mismatch($sformatf("unexpected transfer 0x%02h", m_axis_tdata));
        end else begin
          if (m_axis_tdata[0] !== verdict_q[0])
            report_mismatch($sformatf("deadlock %b, predicted %b",
                                      m_axis_tdata[0], verdict_q[0]));
          if (m_axis_tdata[7:1] !== 7'd0)
            report_mismatch($sformatf("fill bits 0x%02h", m_axis_tdata[7:1]));
          void'(verdict_q.pop_front());
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        graph_edges[s_axis_tdata[3:0]][s_axis_tdata[7:4]] = s_axis_tdata[9:8];
        if (s_axis_tlast) begin
          verdict_q.push_back(wait_graph_cyclic());
          foreach (graph_edges[i, j]) graph_edges[i][j] = KindNone;
        end
      end
      pending_o = verdict_q.size();
    end
  end

endmodule

>>> tb/deadlock_cycle_detector_test.sv
`timescale 1ns / 1ps
module deadlock_cycle_detector_test import dcd_pkg::*;;

  localparam logic [1:0] KindVoid = 2'd3;
  localparam int unsigned StallLimit = 40000;
  localparam int unsigned TargetItems = 950;

  typedef struct packed {
    logic [3:0] proc_idx;
    logic [3:0] res_idx;
    logic [1:0] kind;
  } graph_entry_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;

  int errors;
  int pending;
  int verdicts;
  int deadlocks;
  int entries_sent = 0;
  int graphs_sent = 0;
  int burst_left = 0;
  bit steady_sender = 1'b0;
  int stall_mode = 0;
  int mode_left = 0;
  int idle_cycles = 0;
  int proc_eff = 16;
  int res_eff = 16;
  graph_entry_t entry_q [$];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  deadlock_cycle_detector DUT (.*);

  deadlock_cycle_detector_checker checker_inst (
    .errors_o(errors), .pending_o(pending), .verdicts_o(verdicts),
    .deadlocks_o(deadlocks), .*
  );

  // Receiver: change stall pattern every so often
  always @(posedge clk_i) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left = $urandom_range(20, 300);
    end
    mode_left--;
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= $urandom_range(0, 1);
      2: m_axis_tready <= ($urandom_range(0, 7) == 0);
      default: m_axis_tready <= (mode_left % 4) != 0;
    endcase
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > StallLimit) begin
      $display("timeout after %0d cycles without a transfer", idle_cycles);
      $display("deadlock_cycle_detector_test: done, errors");
      $finish;
    end
  end

  task automatic write_reg(input logic reg_idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Let the checker see the last transfer, wait out every verdict, then the store sweep
  task automatic wait_idle();
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic set_counts(input logic [4:0] np, input logic [4:0] nr);
    wait_idle();
    write_reg(RegNumProcesses, {$urandom_range(0, 1) ? 27'($urandom) : 27'd0, np});
    write_reg(RegNumResources, {$urandom_range(0, 1) ? 27'($urandom) : 27'd0, nr});
    proc_eff = (np == 0) ? 1 : ((np > 16) ? 16 : np);
    res_eff = (nr == 0) ? 1 : ((nr > 16) ? 16 : nr);
  endtask

  // Send one entry, with burst gaps in front of it
  task automatic send_entry(input graph_entry_t e, input logic is_last);
    int gap;
    if (burst_left == 0) begin
      gap = steady_sender ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 19) == 0) steady_sender = !steady_sender;
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'd0, e.kind, e.res_idx, e.proc_idx};
    s_axis_tlast <= is_last;
    do @(posedge clk_i); while (!s_axis_tready);
    entries_sent++;
  endtask

  task automatic send_graph();
    foreach (entry_q[i]) send_entry(entry_q[i], i == entry_q.size() - 1);
    s_axis_tvalid <= 1'b0;
    entry_q.delete();
    graphs_sent++;
  endtask

  function automatic graph_entry_t mk(input int p, input int r, input logic [1:0] k);
    graph_entry_t e;
    e.proc_idx = p[3:0];
    e.res_idx = r[3:0];
    e.kind = k;
    return e;
  endfunction

  // Random graph: mostly rings of hold/request pairs, some loose edges, some noise
  task automatic build_random_graph();
    int style;
    int ring_len;
    int extras;
    int procs [16];
    int ress [16];
    style = $urandom_range(0, 9);
    if (style <= 5) begin
      ring_len = $urandom_range(1, proc_eff < 6 ? proc_eff : 6);
      for (int j = 0; j < ring_len; j++) begin
        procs[j] = $urandom_range(0, proc_eff - 1);
        ress[j] = $urandom_range(0, res_eff - 1);
      end
      for (int j = 0; j < ring_len; j++) begin
        entry_q.push_back(mk(procs[j], ress[j], KindHeld));
        if ($urandom_range(0, 5) != 0)
          entry_q.push_back(mk(procs[j], ress[(j + 1) % ring_len], KindRequest));
      end
    end
    extras = (style <= 5) ? $urandom_range(0, 4) : $urandom_range(1, 16);
    for (int j = 0; j < extras; j++) begin
      if (style == 9)
        entry_q.push_back(mk($urandom_range(0, 15), $urandom_range(0, 15),
                             $urandom_range(0, 3)));
      else
        entry_q.push_back(mk($urandom_range(0, proc_eff - 1), $urandom_range(0, res_eff - 1),
                             $urandom_range(0, 2)));
    end
    if (entry_q.size() == 0 || $urandom_range(0, 4) == 0)
      entry_q.push_back(mk($urandom_range(0, 15), $urandom_range(0, 15), KindNone));
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (40) @(posedge clk_i);

    // Directed: empty graph, self-wait, two-process cycle, open chain
    entry_q.push_back(mk(0, 0, KindNone));
    send_graph();
    entry_q.push_back(mk(3, 5, KindHeld));
    entry_q.push_back(mk(3, 5, KindRequest));
    send_graph();
    entry_q.push_back(mk(15, 15, KindHeld));
    entry_q.push_back(mk(0, 15, KindRequest));
    entry_q.push_back(mk(0, 0, KindHeld));
    entry_q.push_back(mk(15, 0, KindRequest));
    send_graph();
    entry_q.push_back(mk(1, 1, KindHeld));
    entry_q.push_back(mk(2, 1, KindRequest));
    entry_q.push_back(mk(2, 2, KindHeld));
    entry_q.push_back(mk(1, 3, KindRequest));
    send_graph();
    // Kind three erases an edge; a repeated pair overwrites
    entry_q.push_back(mk(4, 4, KindHeld));
    entry_q.push_back(mk(4, 4, KindRequest));
    entry_q.push_back(mk(4, 4, KindVoid));
    send_graph();
    entry_q.push_back(mk(6, 7, KindRequest));
    entry_q.push_back(mk(6, 7, KindHeld));
    entry_q.push_back(mk(6, 7, KindRequest));
    send_graph();
    // Cycle outside the configured counts does not count
    set_counts(5'd4, 5'd4);
    entry_q.push_back(mk(9, 2, KindHeld));
    entry_q.push_back(mk(9, 2, KindRequest));
    entry_q.push_back(mk(1, 9, KindHeld));
    entry_q.push_back(mk(1, 9, KindRequest));
    send_graph();
    // Smallest and clamped counts
    set_counts(5'd0, 5'd0);
    entry_q.push_back(mk(0, 0, KindHeld));
    entry_q.push_back(mk(0, 0, KindRequest));
    send_graph();
    set_counts(5'd31, 5'd31);
    entry_q.push_back(mk(15, 15, KindHeld));
    entry_q.push_back(mk(15, 15, KindRequest));
    send_graph();

    // Random phases through several count settings
    while (entries_sent < TargetItems) begin
      case ($urandom_range(0, 5))
        0: set_counts(5'd16, 5'd16);
        1: set_counts(5'd1, 5'd1);
        2: set_counts(5'd2, $urandom_range(1, 3));
        3: set_counts($urandom_range(0, 31), $urandom_range(0, 31));
        default: set_counts($urandom_range(2, 8), $urandom_range(1, 8));
      endcase
      repeat ($urandom_range(3, 8)) begin
        if (entries_sent >= TargetItems) break;
        build_random_graph();
        send_graph();
      end
    end

    wait_idle();
    $display("%0d entries in %0d graphs sent, %0d verdicts checked, %0d deadlocks",
             entries_sent, graphs_sent, verdicts, deadlocks);
    if (errors == 0) begin
      $display("deadlock_cycle_detector_test: done, clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("deadlock_cycle_detector_test: done, errors");
    end
    $finish;
  end

endmodule
